@@ hw/rtl/bss_pkg.sv @@
// shared types and constants for the safety sequence block
package bss_pkg;
	localparam int DEF_CUSTOMERS = 16;
	localparam int DEF_RESOURCES = 16;
	localparam int AMT_W   = 16;
	localparam int ALLOC_W = 18;
	localparam int WORK_W  = 24;
	localparam int CFG_W   = 5;

	typedef enum logic [2:0] {
		OP_SET_AVAIL = 3'd0,
		OP_SET_MAX   = 3'd1,
		OP_REQUEST   = 3'd2,
		OP_RELEASE   = 3'd3,
		OP_RUN       = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_SEQ     = 3'd0,
		ST_OK      = 3'd1,
		ST_RANGE   = 3'd2,
		ST_UNSAFE  = 3'd3,
		ST_NO_SEQ  = 3'd4
	} status_t;

	localparam logic [1:0] REG_NUM_CUST = 2'd0;
	localparam logic [1:0] REG_NUM_RES  = 2'd1;
endpackage

@@ hw/rtl/bss_table.sv @@
// claim and allocation memories with valid bits for allocation rows
module bss_table #(
	parameter int MAX_CUSTOMERS = bss_pkg::DEF_CUSTOMERS,
	parameter int MAX_RESOURCE_TYPES = bss_pkg::DEF_RESOURCES,
	parameter int AW = $clog2(MAX_CUSTOMERS) + $clog2(MAX_RESOURCE_TYPES)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [AW-1:0] raddr,
	output logic [bss_pkg::AMT_W-1:0] max_rd,
	output logic [bss_pkg::ALLOC_W-1:0] alloc_rd,
	input  logic max_we,
	input  logic alloc_we,
	input  logic [AW-1:0] waddr,
	input  logic [bss_pkg::AMT_W-1:0] max_wd,
	input  logic [bss_pkg::ALLOC_W-1:0] alloc_wd
);
	import bss_pkg::*;
	localparam int DEPTH = 1 << AW;
	logic [AMT_W-1:0] max_mem [DEPTH];
	logic [ALLOC_W-1:0] alloc_mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic vld_rd_q;
	logic [ALLOC_W-1:0] alloc_raw_q;

	always_ff @(posedge clk) begin
		if (max_we) max_mem[waddr] <= max_wd;
		if (alloc_we) alloc_mem[waddr] <= alloc_wd;
		max_rd <= max_mem[raddr];
		alloc_raw_q <= alloc_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (alloc_we) vld_q[waddr] <= 1'b1;
			vld_rd_q <= vld_q[raddr];
		end
	end

	assign alloc_rd = vld_rd_q ? alloc_raw_q : '0;
endmodule

@@ hw/rtl/bankers_safety_sequence.sv @@
// top level: op decode, sequencer and shared compare/add unit
// Set-available and out-of-range items show their result in the cycle after the transfer;
// set-maximum, request and release go through one registered read and one write (states
// TRD and TWR) before their result shows. A run first checks every entry in use for a
// negative need, each entry in turn (address, registered read, compare), and stops with an
// unsafe result at the first one found; it then loads the work vector. Each customer visit
// then passes through the sequencer and compares need against work, resource by resource,
// up to the first one that does not fit; a customer that fits has its allocation added to
// the work vector, resource by resource, and then gives its result. There are up to nc
// passes over the customers. Each result holds until it is taken, and the block is not
// ready for the next item until the last result of the current one has gone.
module bankers_safety_sequence #(
	parameter int MAX_CUSTOMERS = bss_pkg::DEF_CUSTOMERS,
	parameter int MAX_RESOURCE_TYPES = bss_pkg::DEF_RESOURCES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: op[2:0], customer_index[6:3], resource_index[10:7], amount[26:11]
	input  logic [31:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: customer_id[3:0], status[6:4]
	output logic [7:0] m_tdata,
	output logic m_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import bss_pkg::*;
	localparam int CW = $clog2(MAX_CUSTOMERS);
	localparam int RW = (MAX_RESOURCE_TYPES > 1) ? $clog2(MAX_RESOURCE_TYPES) : 1;
	localparam int RB = $clog2(MAX_RESOURCE_TYPES);
	localparam int AW = CW + RB;
	localparam int CC = $clog2(MAX_CUSTOMERS + 1);
	localparam int RC = $clog2(MAX_RESOURCE_TYPES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_TRD, S_TWR, S_NRD, S_NWAIT, S_NCHK, S_WINIT,
		S_FRD, S_FWAIT, S_FCHK, S_ARD, S_AWAIT, S_AADD, S_NEXT, S_OUT
	} state_t;

	state_t state_q, ret_q;
	logic [CFG_W-1:0] ncust_q, nres_q;
	logic [2:0] op_q;
	logic [3:0] ci_q, ri_q;
	logic [AMT_W-1:0] amt_q;
	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [CC-1:0] done_q;
	logic prog_q;
	logic [MAX_CUSTOMERS-1:0] fin_q;
	logic [WORK_W-1:0] work_q [MAX_RESOURCE_TYPES];
	logic [AMT_W-1:0] avail_q [MAX_RESOURCE_TYPES];
	logic fits_q;
	logic [3:0] oid_q;
	logic [2:0] ost_q;
	logic olast_q;

	logic [CC-1:0] nc;
	logic [RC-1:0] nr;
	logic [AW-1:0] raddr, taddr;
	logic [AMT_W-1:0] max_rd;
	logic [ALLOC_W-1:0] alloc_rd, alloc_wd;
	logic alloc_we, max_we;
	logic [WORK_W:0] wsum;
	logic [ALLOC_W:0] asum;
	logic [ALLOC_W-1:0] need;
	logic last_r, last_c;

	always_comb begin
		nc = (ncust_q == '0) ? CC'(1) :
			(32'(ncust_q) > MAX_CUSTOMERS) ? CC'(MAX_CUSTOMERS) : CC'(ncust_q);
		nr = (nres_q == '0) ? RC'(1) :
			(32'(nres_q) > MAX_RESOURCE_TYPES) ? RC'(MAX_RESOURCE_TYPES) : RC'(nres_q);
	end

	if (RB > 0) begin : g_addr
		assign taddr = {CW'(ci_q), RB'(ri_q)};
		assign raddr = (state_q == S_TRD) ? taddr : {c_q, r_q[RB-1:0]};
	end else begin : g_addr1
		assign taddr = CW'(ci_q);
		assign raddr = (state_q == S_TRD) ? taddr : c_q;
	end

	// shared unit: saturating add, subtract floored at zero, or compare against the registered read
	always_comb begin
		asum = {1'b0, alloc_rd} + (ALLOC_W+1)'(amt_q);
		need = ALLOC_W'(max_rd) - alloc_rd;
		wsum = {1'b0, work_q[r_q]} + (WORK_W+1)'(alloc_rd);
		alloc_wd = (op_q == OP_REQUEST) ? (asum[ALLOC_W] ? '1 : asum[ALLOC_W-1:0])
			: ((alloc_rd > ALLOC_W'(amt_q)) ? alloc_rd - ALLOC_W'(amt_q) : '0);
		alloc_we = (state_q == S_TWR) && (op_q == OP_REQUEST || op_q == OP_RELEASE);
		max_we = (state_q == S_TRD) && (op_q == OP_SET_MAX);
		last_r = (RC'(r_q) + RC'(1) == nr);
		last_c = (CC'(c_q) + CC'(1) == nc);
	end

	bss_table #(.MAX_CUSTOMERS(MAX_CUSTOMERS), .MAX_RESOURCE_TYPES(MAX_RESOURCE_TYPES),
		.AW(AW)) u_table (
		.clk(clk), .arst_n(arst_n), .raddr(raddr), .max_rd(max_rd), .alloc_rd(alloc_rd),
		.max_we(max_we), .alloc_we(alloc_we), .waddr(taddr), .max_wd(amt_q),
		.alloc_wd(alloc_wd)
	);

	assign pready = 1'b1;
	always_comb begin
		case (paddr[2])
			REG_NUM_CUST[0]: prdata = 32'(ncust_q);
			default:         prdata = 32'(nres_q);
		endcase
		if (paddr[2:0] > 3'd4) prdata = '0;
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {1'b0, ost_q, oid_q};
	assign m_tlast = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			ncust_q <= CFG_W'(5);
			nres_q <= CFG_W'(4);
			fin_q <= '0;
			for (int i = 0; i < MAX_RESOURCE_TYPES; i++) avail_q[i] <= '0;
			for (int i = 0; i < MAX_RESOURCE_TYPES; i++) work_q[i] <= '0;
			op_q <= '0; c_q <= '0; r_q <= '0; done_q <= '0; prog_q <= 1'b0;
			fits_q <= 1'b0; olast_q <= 1'b0; oid_q <= '0; ost_q <= '0;
			ci_q <= '0; ri_q <= '0; amt_q <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr == 3'd0) ncust_q <= pwdata[CFG_W-1:0];
				else if (paddr == 3'd4) nres_q <= pwdata[CFG_W-1:0];
			end
			case (state_q)
				S_IDLE: if (s_tvalid) begin
					op_q <= s_tdata[2:0];
					ci_q <= s_tdata[6:3];
					ri_q <= s_tdata[10:7];
					amt_q <= s_tdata[26:11];
					oid_q <= '0;
					olast_q <= 1'b1;
					ret_q <= S_IDLE;
					c_q <= '0; r_q <= '0;
					if (s_tdata[2:0] == OP_RUN) begin
						state_q <= S_NRD;
					end else if (s_tdata[2:0] > OP_RUN || 8'(s_tdata[10:7]) >= 8'(nr)
						|| (s_tdata[2:0] != OP_SET_AVAIL && 8'(s_tdata[6:3]) >= 8'(nc))) begin
						ost_q <= ST_RANGE;
						state_q <= S_OUT;
					end else if (s_tdata[2:0] == OP_SET_AVAIL) begin
						avail_q[RW'(s_tdata[10:7])] <= s_tdata[26:11];
						ost_q <= ST_OK;
						state_q <= S_OUT;
					end else begin
						state_q <= S_TRD;
					end
				end
				S_TRD: state_q <= S_TWR;
				S_TWR: begin
					ost_q <= ST_OK;
					state_q <= S_OUT;
				end
				S_NRD: state_q <= S_NWAIT;
				S_NWAIT: state_q <= S_NCHK;
				S_NCHK: begin
					if (alloc_rd > ALLOC_W'(max_rd)) begin
						ost_q <= ST_UNSAFE; olast_q <= 1'b1;
						state_q <= S_OUT;
					end else if (!last_r) begin
						r_q <= r_q + RW'(1); state_q <= S_NRD;
					end else if (!last_c) begin
						r_q <= '0; c_q <= c_q + CW'(1); state_q <= S_NRD;
					end else begin
						r_q <= '0; c_q <= '0; state_q <= S_WINIT;
					end
				end
				S_WINIT: begin
					for (int i = 0; i < MAX_RESOURCE_TYPES; i++)
						work_q[i] <= WORK_W'(avail_q[i]);
					fin_q <= '0; done_q <= '0; prog_q <= 1'b0;
					fits_q <= 1'b1;
					state_q <= S_NEXT;
					ret_q <= S_FRD;
				end
				S_FRD: state_q <= S_FWAIT;
				S_FWAIT: state_q <= S_FCHK;
				S_FCHK: begin
					if (WORK_W'(need) > work_q[r_q]) begin
						r_q <= '0; ret_q <= S_IDLE; state_q <= S_NEXT;
						c_q <= c_q;
						fits_q <= 1'b0;
					end else if (!last_r) begin
						r_q <= r_q + RW'(1); state_q <= S_FRD;
					end else begin
						r_q <= '0; state_q <= S_ARD;
					end
				end
				S_ARD: state_q <= S_AWAIT;
				S_AWAIT: state_q <= S_AADD;
				S_AADD: begin
					work_q[r_q] <= wsum[WORK_W] ? '1 : wsum[WORK_W-1:0];
					if (!last_r) begin
						r_q <= r_q + RW'(1); state_q <= S_ARD;
					end else begin
						r_q <= '0;
						fin_q[c_q] <= 1'b1;
						done_q <= done_q + CC'(1);
						prog_q <= 1'b1;
						oid_q <= 4'(c_q);
						ost_q <= ST_SEQ;
						olast_q <= (done_q + CC'(1) == nc);
						ret_q <= S_NEXT;
						fits_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				// pick the next customer to try, finish the run, or report that no safe sequence exists
				S_NEXT: begin
					if (fits_q) begin
						// fits_q set: try the current customer unless it has already finished
						fits_q <= 1'b0;
						if (!fin_q[c_q]) state_q <= S_FRD;
						else state_q <= S_NEXT;
						ret_q <= S_IDLE;
					end else if (done_q == nc) begin
						state_q <= S_IDLE;
					end else if (!last_c) begin
						c_q <= c_q + CW'(1);
						fits_q <= 1'b1;
					end else if (prog_q) begin
						c_q <= '0; prog_q <= 1'b0; fits_q <= 1'b1;
					end else begin
						oid_q <= '0; ost_q <= ST_NO_SEQ; olast_q <= 1'b1;
						ret_q <= S_IDLE;
						state_q <= S_OUT;
					end
				end
				S_OUT: if (m_tready) begin
					state_q <= (ret_q == S_NEXT) ? S_NEXT : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/bss_checker.sv @@
// port-level checks for the safety sequence block, bound to the top level
module bss_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [7:0] m_tdata,
	input logic m_tlast
);
	import bss_pkg::*;
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped under stall");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:4] != ST_SEQ |-> m_tlast) else $error("status result not last");
	a_err_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:4] != ST_SEQ |-> m_tdata[3:0] == 4'd0)
		else $error("nonzero id on status result");
endmodule

bind bankers_safety_sequence bss_checker u_bss_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
